// ===== rtl/core/cld_pkg.sv =====
// cld_pkg: shared types and constants of the centred linear deque.
// Holds the operation and status codes and the fixed field widths.
// No dependencies.
package cld_pkg;

  // Fixed field widths of the item channels
  localparam int unsigned ValueW  = 32;
  localparam int unsigned IndexW  = 7;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 8;

  // Operation codes
  typedef enum logic [ModeW-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_READ_AT    = 3'd4
  } mode_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

endpackage

// ===== rtl/core/cld_if.sv =====
// cld_in_if / cld_out_if: valid-ready channels of the centred linear deque.
// Payload widths come from cld_pkg.
interface cld_in_if import cld_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ModeW-1:0]  mode;
  logic [ValueW-1:0] value;
  logic [IndexW-1:0] index;

  modport source (output valid, output mode, output value, output index, input ready);
  modport sink   (input valid, input mode, input value, input index, output ready);
endinterface

interface cld_out_if import cld_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ValueW-1:0]  data;
  logic [StatusW-1:0] status;
  logic [CountW-1:0]  count;

  modport source (output valid, output data, output status, output count, input ready);
  modport sink   (input valid, input data, input status, input count, output ready);
endinterface

// ===== rtl/core/centered_linear_deque.sv =====
// centered_linear_deque: double-ended queue held in one flat line of slots.
// Depends on cld_pkg and on the channel interfaces in cld_if.sv.
//
//   channel | dir | payload                     | handshake
//   --------+-----+-----------------------------+--------------------
//   in_i    | in  | mode, value, index          | valid/ready, sink
//   out_o   | out | data, status, count         | valid/ready, source
//
// One item per cycle while no result is stalled: the pointers update and
// the single store port is written or read at the accepting edge, the read
// word lands in the result register; the result shows in the next cycle.
// Reset (rst_ni low, asynchronous) empties the deque and clears out_o.valid;
// the store itself is not cleared.
// While a result waits and out_o.ready is low, in_i.ready is low.
module centered_linear_deque import cld_pkg::*; #(
  parameter int unsigned DEPTH      = 128,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  cld_in_if.sink    in_i,
  cld_out_if.source out_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned SumW = ((PtrW > IndexW) ? PtrW : IndexW) + 1;
  localparam logic [PtrW-1:0] Mid  = PtrW'(DEPTH / 2);
  localparam logic [PtrW-1:0] Last = PtrW'(DEPTH - 1);

  // Deque state
  logic [PtrW-1:0] front_q, front_d;
  logic [PtrW-1:0] back_q, back_d;
  logic            empty_q, empty_d;

  // Result register
  logic                  out_valid_q;
  logic                  use_rd_q, use_rd;
  status_e               status_q, status_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [DATA_WIDTH-1:0] rdata_q;

  // Store
  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic                  wr_en;
  logic [PtrW-1:0]       wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0] wr_word;
  logic [SumW-1:0]       read_sum;
  logic                  accept;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign wr_word    = DATA_WIDTH'(in_i.value);
  assign read_sum   = SumW'(front_q) + SumW'(in_i.index);

  // Operation decode and pointer update
  always_comb begin
    front_d  = front_q;
    back_d   = back_q;
    empty_d  = empty_q;
    wr_en    = 1'b0;
    wr_addr  = front_q;
    rd_addr  = front_q;
    use_rd   = 1'b0;
    status_d = ST_OK;
    unique case (mode_e'(in_i.mode))
      MODE_PUSH_FRONT: begin
        if (empty_q) begin
          front_d = Mid;
          back_d  = Mid;
          empty_d = 1'b0;
          wr_en   = 1'b1;
          wr_addr = Mid;
        end else if (front_q == '0) begin
          status_d = ST_FULL;
        end else begin
          front_d = front_q - PtrW'(1);
          wr_en   = 1'b1;
          wr_addr = front_q - PtrW'(1);
        end
      end
      MODE_PUSH_BACK: begin
        if (empty_q) begin
          front_d = Mid;
          back_d  = Mid;
          empty_d = 1'b0;
          wr_en   = 1'b1;
          wr_addr = Mid;
        end else if (back_q >= Last) begin
          status_d = ST_FULL;
        end else begin
          back_d  = back_q + PtrW'(1);
          wr_en   = 1'b1;
          wr_addr = back_q + PtrW'(1);
        end
      end
      MODE_POP_FRONT: begin
        if (empty_q) begin
          status_d = ST_EMPTY;
        end else begin
          rd_addr = front_q;
          use_rd  = 1'b1;
          if (front_q == back_q) begin
            front_d = Mid;
            back_d  = Mid;
            empty_d = 1'b1;
          end else begin
            front_d = front_q + PtrW'(1);
          end
        end
      end
      MODE_POP_BACK: begin
        if (empty_q) begin
          status_d = ST_EMPTY;
        end else begin
          rd_addr = back_q;
          use_rd  = 1'b1;
          if (front_q == back_q) begin
            front_d = Mid;
            back_d  = Mid;
            empty_d = 1'b1;
          end else begin
            back_d = back_q - PtrW'(1);
          end
        end
      end
      MODE_READ_AT: begin
        if (empty_q) begin
          status_d = ST_EMPTY;
        end else if (read_sum > SumW'(back_q)) begin
          status_d = ST_RANGE;
        end else begin
          // in range, so the sum is below DEPTH
          rd_addr = read_sum[PtrW-1:0];
          use_rd  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Element count after this item
  assign count_d = empty_d ? '0 : CntW'(back_d - front_d) + CntW'(1);

  // Deque state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= Mid;
      back_q  <= Mid;
      empty_q <= 1'b1;
    end else if (accept) begin
      front_q <= front_d;
      back_q  <= back_d;
      empty_q <= empty_d;
    end
  end

  // Single-port store, read data registered
  always_ff @(posedge clk_i) begin
    if (accept && wr_en) begin
      mem_q[wr_addr] <= wr_word;
    end
    if (accept && use_rd) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      use_rd_q <= use_rd;
      status_q <= status_d;
      count_q  <= count_d;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.data   = use_rd_q ? ValueW'(rdata_q) : '0;
  assign out_o.status = status_q;
  assign out_o.count  = CountW'(count_q);

endmodule

// ===== rtl/core/cld_checker.sv =====
// cld_checker: port-level checks on the centred linear deque result channel.
// Depends on cld_pkg; bound to centered_linear_deque below.
module cld_checker import cld_pkg::*; #(
  parameter int unsigned DEPTH = 128
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [ValueW-1:0]  out_data_i,
  input logic [StatusW-1:0] out_status_i,
  input logic [CountW-1:0]  out_count_i
);

  // A stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_data_i) && $stable(out_status_i) && $stable(out_count_i))
    else $error("result changed while stalled");

  // An empty failure means nothing is held and no word comes back
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == ST_EMPTY |-> out_data_i == '0 && out_count_i == '0)
    else $error("empty status with data or count");

  // Refused pushes and out-of-range reads return zero on a non-empty deque
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == ST_FULL || out_status_i == ST_RANGE) |->
      out_data_i == '0 && out_count_i != '0)
    else $error("failure status with data or zero count");

  // Count never exceeds the store size (checked only when DEPTH is at most 255)
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (DEPTH > 255) || (32'(out_count_i) <= DEPTH))
    else $error("count beyond depth");

endmodule

bind centered_linear_deque cld_checker #(.DEPTH(DEPTH)) u_cld_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_data_i   (out_o.data),
  .out_status_i (out_o.status),
  .out_count_i  (out_o.count)
);
